FILE: hw/rtl/amr_pkg.sv
// amr_pkg: shared types and constants for the rectangle move resolver.
// No dependencies; compiled first.
`timescale 1ns / 1ps
`default_nettype none

package amr_pkg;

   localparam int AmrMaxBlockers = 64;
   localparam int AmrCoordBits   = 24;

   typedef enum logic {
      CMD_WRITE   = 1'b0,
      CMD_RESOLVE = 1'b1
   } cmd_type;

   // Slots of the query word that travels down the cell chain.
   localparam int Q_SX0      = 0;  // mover left, shifted by move_x
   localparam int Q_SX1      = 1;  // mover right, shifted by move_x
   localparam int Q_UX0      = 2;  // mover left, unshifted
   localparam int Q_UX1      = 3;  // mover right, unshifted
   localparam int Q_UY0      = 4;  // mover top, unshifted
   localparam int Q_UY1      = 5;  // mover bottom, unshifted
   localparam int Q_MY0      = 6;  // mover top, shifted by move_y
   localparam int Q_MY1      = 7;  // mover bottom, shifted by move_y
   localparam int QuerySlots = 8;

   // Hit accumulators carried alongside the query.
   typedef struct packed {
      logic valid;
      logic hit_x;   // shifted x, unshifted y
      logic hit_ym;  // shifted x, shifted y
      logic hit_ys;  // unshifted x, shifted y
   } hit_type;

endpackage

`default_nettype wire

FILE: hw/rtl/amr_if.sv
// amr_req_if / amr_rsp_if: valid/ready channels of the move resolver.
// Depends on amr_pkg.
`timescale 1ns / 1ps
`default_nettype none

interface amr_req_if import amr_pkg::*; #(
   parameter int COORD_BITS = AmrCoordBits,
   parameter int INDEX_BITS = $clog2(AmrMaxBlockers)
) ();
   logic                         valid;
   logic                         ready;
   cmd_type                      command;
   logic        [INDEX_BITS-1:0] index;
   logic signed [COORD_BITS-1:0] rect_x;
   logic signed [COORD_BITS-1:0] rect_y;
   logic        [COORD_BITS-2:0] rect_w;
   logic        [COORD_BITS-2:0] rect_h;
   logic signed [COORD_BITS-1:0] move_x;
   logic signed [COORD_BITS-1:0] move_y;

   modport source (output valid, command, index, rect_x, rect_y, rect_w, rect_h,
                   move_x, move_y, input ready);
   modport sink (input valid, command, index, rect_x, rect_y, rect_w, rect_h,
                 move_x, move_y, output ready);
endinterface

interface amr_rsp_if import amr_pkg::*; #(
   parameter int COORD_BITS = AmrCoordBits
) ();
   logic                         valid;
   logic                         ready;
   logic signed [COORD_BITS-1:0] resolved_x;
   logic signed [COORD_BITS-1:0] resolved_y;
   logic                         x_blocked;
   logic                         y_blocked;

   modport source (output valid, resolved_x, resolved_y, x_blocked, y_blocked,
                   input ready);
   modport sink (input valid, resolved_x, resolved_y, x_blocked, y_blocked,
                 output ready);
endinterface

`default_nettype wire

FILE: hw/rtl/amr_cell.sv
// amr_cell: one blocker slot of the chain; tests the passing query against it.
// Depends on amr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module amr_cell import amr_pkg::*; #(
   parameter int COORD_BITS = AmrCoordBits
) (
   input  wire logic                                  clock,
   input  wire logic                                  reset,
   input  wire logic                                  wr_en,
   input  wire logic        [COORD_BITS-1:0]          wr_x0,
   input  wire logic        [COORD_BITS-1:0]          wr_x1,
   input  wire logic        [COORD_BITS-1:0]          wr_y0,
   input  wire logic        [COORD_BITS-1:0]          wr_y1,
   input  wire logic                                  active,
   input  wire logic [QuerySlots-1:0][COORD_BITS-1:0] q_in,
   input  wire hit_type                               hit_in,
   output logic      [QuerySlots-1:0][COORD_BITS-1:0] q_out,
   output hit_type                                    hit_out
);

   logic [COORD_BITS-1:0] bx0_ff, bx1_ff, by0_ff, by1_ff;
   logic [QuerySlots-1:0][COORD_BITS-1:0] q_ff;
   hit_type hit_ff, hit_in_next;
   logic ox_s, ox_u, oy_u, oy_m;

   // Strict open-interval overlap, signed compare.
   function automatic logic span_hit(input logic [COORD_BITS-1:0] a0,
                                     input logic [COORD_BITS-1:0] a1,
                                     input logic [COORD_BITS-1:0] b0,
                                     input logic [COORD_BITS-1:0] b1);
      return ($signed(a0) < $signed(b1)) && ($signed(a1) > $signed(b0));
   endfunction

   always_ff @(posedge clock) begin
      if (wr_en) begin
         bx0_ff <= wr_x0;
         bx1_ff <= wr_x1;
         by0_ff <= wr_y0;
         by1_ff <= wr_y1;
      end
   end

   always_comb begin
      ox_s = span_hit(q_in[Q_SX0], q_in[Q_SX1], bx0_ff, bx1_ff);
      ox_u = span_hit(q_in[Q_UX0], q_in[Q_UX1], bx0_ff, bx1_ff);
      oy_u = span_hit(q_in[Q_UY0], q_in[Q_UY1], by0_ff, by1_ff);
      oy_m = span_hit(q_in[Q_MY0], q_in[Q_MY1], by0_ff, by1_ff);
      hit_in_next        = hit_in;
      hit_in_next.hit_x  = hit_in.hit_x  | (active & ox_s & oy_u);
      hit_in_next.hit_ym = hit_in.hit_ym | (active & ox_s & oy_m);
      hit_in_next.hit_ys = hit_in.hit_ys | (active & ox_u & oy_m);
   end

   always_ff @(posedge clock) begin
      q_ff <= q_in;
      if (reset) begin
         hit_ff <= '0;
      end else begin
         hit_ff <= hit_in_next;
      end
   end

   assign q_out   = q_ff;
   assign hit_out = hit_ff;

endmodule

`default_nettype wire

FILE: hw/rtl/aabb_move_resolver.sv
// aabb_move_resolver: top level; blocker cell chain, query prep and result stage.
// Depends on amr_pkg, amr_req_if, amr_rsp_if and amr_cell.
`timescale 1ns / 1ps
`default_nettype none

// Channel  Ports        Dir  Transfer
// -------  -----------  ---  ------------------------------------------------
// request  req_ch.*     in   write a blocker (no result) or resolve a move
// response rsp_ch.*     out  resolved move and blocked flags, one per resolve
// control  csr_wr_*     in   blocker_count, taken on any edge with csr_wr_en
//
// A write transfer lands in its cell at the accepting edge; the next request can
// follow in the next cycle. A resolve reaches rsp_ch.valid through the prep stage,
// loaded at its accepting edge, then one stage per cell, one result stage and the
// output register; the move into the output register waits while it stalls. One
// resolve is in flight at a time: the next request is taken once the result has
// moved into the output register, even while that register stalls. Reset clears
// the control and count state only; blocker entries hold garbage until written.

module aabb_move_resolver import amr_pkg::*; #(
   parameter int MAX_BLOCKERS = AmrMaxBlockers,
   parameter int COORD_BITS   = AmrCoordBits
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   amr_req_if.sink                     req_ch,
   amr_rsp_if.source                   rsp_ch,
   input  wire logic                   csr_wr_en,
   input  wire logic [$clog2(MAX_BLOCKERS+1)-1:0] csr_wr_data
);

   localparam int COUNT_BITS = $clog2(MAX_BLOCKERS + 1);
   localparam int INDEX_BITS = (MAX_BLOCKERS > 1) ? $clog2(MAX_BLOCKERS) : 1;

   // Control and count.
   logic                  busy_ff, busy_in;
   logic [COUNT_BITS-1:0] count_ff;
   logic                  req_fire, wr_go, rs_go;

   // Query prep stage feeding cell 0.
   logic [QuerySlots-1:0][COORD_BITS-1:0] query_ff, query_in;
   hit_type                               launch_ff;
   logic [COORD_BITS-1:0]                 move_x_ff, move_y_ff;

   // Blocker write data, right and bottom edges wrapped.
   logic [COORD_BITS-1:0] wr_x1, wr_y1, w_ext, h_ext;

   // Chain wiring: element 0 is the prep stage, element i+1 is cell i's output.
   logic [QuerySlots-1:0][COORD_BITS-1:0] q_chain [MAX_BLOCKERS+1];
   hit_type                               hit_chain [MAX_BLOCKERS+1];
   hit_type                               tail;

   // Result stage and output register.
   logic                  res_valid_ff, res_valid_in;
   logic [COORD_BITS-1:0] res_x_ff, res_y_ff;
   logic                  res_xb_ff, res_yb_ff;
   logic                  tail_xb, tail_yb;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic [COORD_BITS-1:0] rsp_x_ff, rsp_y_ff;
   logic                  rsp_xb_ff, rsp_yb_ff;
   logic                  rsp_free, res_move;

   assign req_ch.ready = !busy_ff;
   assign req_fire     = req_ch.valid && req_ch.ready;
   assign wr_go        = req_fire && (req_ch.command == CMD_WRITE);
   assign rs_go        = req_fire && (req_ch.command == CMD_RESOLVE);

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
      end else if (csr_wr_en) begin
         count_ff <= csr_wr_data;
      end
   end

   // Widths and heights are unsigned; zero-extend before the wrapping add.
   assign w_ext = COORD_BITS'({1'b0, req_ch.rect_w});
   assign h_ext = COORD_BITS'({1'b0, req_ch.rect_h});
   assign wr_x1 = req_ch.rect_x + w_ext;
   assign wr_y1 = req_ch.rect_y + h_ext;

   // Three mover placements are tested in one pass: x-shifted for the x test,
   // and for the y test both x-shifted and unshifted, picked at the tail.
   always_comb begin
      query_in        = '0;
      query_in[Q_SX0] = req_ch.rect_x + req_ch.move_x;
      query_in[Q_SX1] = req_ch.rect_x + req_ch.move_x + w_ext;
      query_in[Q_UX0] = req_ch.rect_x;
      query_in[Q_UX1] = wr_x1;
      query_in[Q_UY0] = req_ch.rect_y;
      query_in[Q_UY1] = wr_y1;
      query_in[Q_MY0] = req_ch.rect_y + req_ch.move_y;
      query_in[Q_MY1] = req_ch.rect_y + req_ch.move_y + h_ext;
   end

   always_ff @(posedge clock) begin
      if (rs_go) begin
         query_ff  <= query_in;
         move_x_ff <= req_ch.move_x;
         move_y_ff <= req_ch.move_y;
      end
      if (reset) begin
         launch_ff <= '0;
      end else begin
         launch_ff <= '{valid: rs_go, default: 1'b0};
      end
   end

   assign q_chain[0]   = query_ff;
   assign hit_chain[0] = launch_ff;

   for (genvar i = 0; i < MAX_BLOCKERS; i++) begin : g_cell
      logic cell_we, cell_active;
      // Writes beyond the table match no cell and fall away.
      assign cell_we     = wr_go && (req_ch.index == INDEX_BITS'(i));
      // A count above the table size leaves every cell active.
      assign cell_active = (COUNT_BITS'(i) < count_ff);

      amr_cell #(
         .COORD_BITS (COORD_BITS)
      ) u_cell (
         .clock   (clock),
         .reset   (reset),
         .wr_en   (cell_we),
         .wr_x0   (req_ch.rect_x),
         .wr_x1   (wr_x1),
         .wr_y0   (req_ch.rect_y),
         .wr_y1   (wr_y1),
         .active  (cell_active),
         .q_in    (q_chain[i]),
         .hit_in  (hit_chain[i]),
         .q_out   (q_chain[i+1]),
         .hit_out (hit_chain[i+1])
      );
   end

   assign tail    = hit_chain[MAX_BLOCKERS];
   assign tail_xb = tail.hit_x;
   // The y test uses whichever x move survived.
   assign tail_yb = tail_xb ? tail.hit_ys : tail.hit_ym;

   assign rsp_free = !rsp_valid_ff || rsp_ch.ready;
   assign res_move = res_valid_ff && rsp_free;

   always_comb begin
      busy_in      = busy_ff;
      res_valid_in = res_valid_ff;
      rsp_valid_in = rsp_valid_ff;
      if (rs_go) begin
         busy_in = 1'b1;
      end
      if (res_move) begin
         busy_in = 1'b0;
      end
      if (tail.valid) begin
         res_valid_in = 1'b1;
      end else if (res_move) begin
         res_valid_in = 1'b0;
      end
      if (res_move) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ch.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff      <= 1'b0;
         res_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         busy_ff      <= busy_in;
         res_valid_ff <= res_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (tail.valid) begin
         res_x_ff  <= tail_xb ? '0 : move_x_ff;
         res_y_ff  <= tail_yb ? '0 : move_y_ff;
         res_xb_ff <= tail_xb;
         res_yb_ff <= tail_yb;
      end
      if (res_move) begin
         rsp_x_ff  <= res_x_ff;
         rsp_y_ff  <= res_y_ff;
         rsp_xb_ff <= res_xb_ff;
         rsp_yb_ff <= res_yb_ff;
      end
   end

   assign rsp_ch.valid      = rsp_valid_ff;
   assign rsp_ch.resolved_x = rsp_x_ff;
   assign rsp_ch.resolved_y = rsp_y_ff;
   assign rsp_ch.x_blocked  = rsp_xb_ff;
   assign rsp_ch.y_blocked  = rsp_yb_ff;

   // Occupancy of the resolve path, for the checks below.
   logic [MAX_BLOCKERS+1:0] inflight;
   always_comb begin
      inflight[0] = launch_ff.valid;
      for (int i = 1; i <= MAX_BLOCKERS; i++) begin
         inflight[i] = hit_chain[i].valid;
      end
      inflight[MAX_BLOCKERS+1] = res_valid_ff;
   end

   // At most one resolve anywhere between prep and result stage.
   a_single_resolve: assert property (@(posedge clock) disable iff (reset)
      $countones(inflight) <= 1)
      else $error("more than one resolve in flight");

   // The request side stays closed from a resolve accept until its result moves on.
   a_busy_covers: assert property (@(posedge clock) disable iff (reset)
      (inflight != '0) |-> !req_ch.ready)
      else $error("request accepted while a resolve is in flight");

   // A blocked axis always reports a zero move.
   a_blocked_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_ch.valid |-> ((!rsp_ch.x_blocked || rsp_ch.resolved_x == '0) &&
                        (!rsp_ch.y_blocked || rsp_ch.resolved_y == '0)))
      else $error("blocked axis with nonzero move");

   // Every launch from the prep stage reaches the tail of the cell chain.
   a_chain_latency: assert property (@(posedge clock) disable iff (reset)
      launch_ff.valid |-> ##MAX_BLOCKERS tail.valid)
      else $error("resolve lost in the cell chain");

endmodule

`default_nettype wire

FILE: tb/aabb_move_resolver_test.sv
// aabb_move_resolver_test: self-checking bench for the rectangle move resolver.
// Depends on amr_pkg, amr_req_if, amr_rsp_if and aabb_move_resolver.
`timescale 1ns / 1ps

module aabb_move_resolver_test;
   import amr_pkg::*;

   localparam int CB    = AmrCoordBits;
   localparam int IDX_W = $clog2(AmrMaxBlockers);
   localparam int CNT_W = $clog2(AmrMaxBlockers + 1);
   localparam int ONE   = 256;                     // 1.0 in Q15.8

   // accepting edge to rsp valid: prep loads at that edge, then one stage per cell,
   // the result stage and the output reg
   localparam int RESOLVE_LATENCY = AmrMaxBlockers + 2;
   // longest quiet stretch of a correct run is the pressure hold plus one resolve
   localparam int HOLD_CYCLES     = 400;
   localparam int WATCHDOG_LIMIT  = 4000;

   localparam int COORD_MAX = 8388607;
   localparam int COORD_MIN = -8388608;

   typedef logic signed [CB-1:0] coord_t;
   typedef logic        [CB-2:0] extent_t;
   typedef logic     [IDX_W-1:0] slot_t;

   typedef struct packed {
      cmd_type command;
      slot_t   index;
      coord_t  rect_x;
      coord_t  rect_y;
      extent_t rect_w;
      extent_t rect_h;
      coord_t  move_x;
      coord_t  move_y;
   } move_req_t;

   typedef struct packed {
      coord_t res_x;
      coord_t res_y;
      logic   x_blk;
      logic   y_blk;
   } move_rsp_t;

   logic clock = 1'b0;
   logic reset;
   logic             csr_wr_en;
   logic [CNT_W-1:0] csr_wr_data;

   amr_req_if req_ch();
   amr_rsp_if rsp_ch();

   aabb_move_resolver dut (
      .clock       (clock),
      .reset       (reset),
      .req_ch      (req_ch),
      .rsp_ch      (rsp_ch),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   always #6 clock = ~clock;

   // Shadow of the blocker table and the count register, updated on each transfer.
   coord_t           blk_x [AmrMaxBlockers];
   coord_t           blk_y [AmrMaxBlockers];
   extent_t          blk_w [AmrMaxBlockers];
   extent_t          blk_h [AmrMaxBlockers];
   logic [CNT_W-1:0] active_blockers;

   move_rsp_t pending_moves[$];   // resolved moves still owed by the block
   move_rsp_t checked_move;

   int send_idle_pct   = 0;
   int recv_idle_pct   = 0;
   int rsp_hold_cycles = 0;
   int quiet_cycles    = 0;
   int fail_count      = 0;
   int writes_sent     = 0;
   int resolves_sent   = 0;
   int resolves_checked = 0;
   int x_stops         = 0;
   int y_stops         = 0;

   // ---------------------------------------------------------------------------
   // Collision predictor
   // ---------------------------------------------------------------------------

   // Strict overlap of the mover against the active part of the table. Every edge
   // sum wraps to CB bits before the signed compare, so a far edge that runs past
   // the top of the range turns negative and never overlaps anything above it.
   function automatic logic hits_blocker(input coord_t px, input coord_t py,
                                         input extent_t pw, input extent_t ph);
      coord_t ax1;
      coord_t ay1;
      coord_t bx1;
      coord_t by1;
      int     n;
      logic   hit;
      hit = 1'b0;
      // count register above table depth covers the whole table
      n = (active_blockers > AmrMaxBlockers) ? AmrMaxBlockers : int'(active_blockers);
      ax1 = px + {1'b0, pw};
      ay1 = py + {1'b0, ph};
      for (int i = 0; i < n; i++) begin
         bx1 = blk_x[i] + {1'b0, blk_w[i]};
         by1 = blk_y[i] + {1'b0, blk_h[i]};
         if (px < bx1 && ax1 > blk_x[i] && py < by1 && ay1 > blk_y[i])
            hit = 1'b1;
      end
      return hit;
   endfunction

   // X first on the unshifted y; the y test then rides on the x move that survived.
   function automatic move_rsp_t resolve_move(input move_req_t r);
      move_rsp_t o;
      coord_t    sx;
      coord_t    sy;
      sx      = r.rect_x + r.move_x;
      o.x_blk = hits_blocker(sx, r.rect_y, r.rect_w, r.rect_h);
      o.res_x = o.x_blk ? coord_t'(0) : r.move_x;
      sx      = r.rect_x + o.res_x;
      sy      = r.rect_y + r.move_y;
      o.y_blk = hits_blocker(sx, sy, r.rect_w, r.rect_h);
      o.res_y = o.y_blk ? coord_t'(0) : r.move_y;
      return o;
   endfunction

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   function automatic move_req_t make_req(input cmd_type c, input int idx,
                                          input int x, input int y, input int w,
                                          input int h, input int mx, input int my);
      move_req_t r;
      r.command = c;
      r.index   = slot_t'(idx);
      r.rect_x  = coord_t'(x);
      r.rect_y  = coord_t'(y);
      r.rect_w  = extent_t'(w);
      r.rect_h  = extent_t'(h);
      r.move_x  = coord_t'(mx);
      r.move_y  = coord_t'(my);
      return r;
   endfunction

   // Most items live in a small arena so that hits are common; a few use raw
   // full-width values so every bit of every field toggles.
   function automatic move_req_t random_request();
      move_req_t r;
      bit        wide;
      wide      = ($urandom_range(99) < 12);
      r.command = ($urandom_range(99) < 40) ? CMD_WRITE : CMD_RESOLVE;
      r.index   = slot_t'($urandom);
      if (wide) begin
         r.rect_x = coord_t'($urandom);
         r.rect_y = coord_t'($urandom);
         r.rect_w = extent_t'($urandom);
         r.rect_h = extent_t'($urandom);
         r.move_x = coord_t'($urandom);
         r.move_y = coord_t'($urandom);
      end else begin
         r.rect_x = coord_t'(int'($urandom_range(48 * ONE)) - 24 * ONE);
         r.rect_y = coord_t'(int'($urandom_range(48 * ONE)) - 24 * ONE);
         r.rect_w = extent_t'($urandom_range(8 * ONE));
         r.rect_h = extent_t'($urandom_range(8 * ONE));
         r.move_x = coord_t'(int'($urandom_range(12 * ONE)) - 6 * ONE);
         r.move_y = coord_t'(int'($urandom_range(12 * ONE)) - 6 * ONE);
      end
      return r;
   endfunction

   // Offer one item, with random idle cycles in front, and hold it until the
   // transfer. The shadow state moves at the accepting edge, in transfer order.
   task automatic send_move_request(input move_req_t item);
      @(negedge clock);
      while ($urandom_range(99) < send_idle_pct) begin
         req_ch.valid = 1'b0;
         @(negedge clock);
      end
      req_ch.command = item.command;
      req_ch.index   = item.index;
      req_ch.rect_x  = item.rect_x;
      req_ch.rect_y  = item.rect_y;
      req_ch.rect_w  = item.rect_w;
      req_ch.rect_h  = item.rect_h;
      req_ch.move_x  = item.move_x;
      req_ch.move_y  = item.move_y;
      req_ch.valid   = 1'b1;
      do @(posedge clock); while (req_ch.ready !== 1'b1);
      if (item.command == CMD_WRITE) begin
         blk_x[item.index] = item.rect_x;
         blk_y[item.index] = item.rect_y;
         blk_w[item.index] = item.rect_w;
         blk_h[item.index] = item.rect_h;
         writes_sent++;
      end else begin
         checked_move = resolve_move(item);
         pending_moves.push_back(checked_move);
         resolves_sent++;
         x_stops += checked_move.x_blk;
         y_stops += checked_move.y_blk;
      end
   endtask

   // Stop offering, wait out every owed response, then let a resolve's worth of
   // cycles pass so nothing is still in the cell chain.
   task automatic wait_block_idle();
      @(negedge clock);
      req_ch.valid = 1'b0;
      while (pending_moves.size() != 0)
         @(posedge clock);
      repeat (RESOLVE_LATENCY + 4) @(posedge clock);
   endtask

   task automatic write_blocker_count(input int count);
      wait_block_idle();
      @(negedge clock);
      csr_wr_en   = 1'b1;
      csr_wr_data = CNT_W'(count);
      @(posedge clock);
      active_blockers = CNT_W'(count);
      @(negedge clock);
      csr_wr_en = 1'b0;
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // Count is zero out of reset: nothing may block, even a mover covering
   // everything. The table is still unwritten, so only resolves go in.
   task automatic test_zero_count();
      send_move_request(make_req(CMD_RESOLVE, 0, 0, 0, COORD_MAX, COORD_MAX,
                                 COORD_MAX, COORD_MIN));
      send_move_request(make_req(CMD_RESOLVE, 21, COORD_MIN, COORD_MIN, 0, 0, 0, 0));
   endtask

   // A vertical wall (entry 0) and a short floor (entry 1).
   task automatic test_axis_blocking();
      send_move_request(make_req(CMD_WRITE, 0, 10 * ONE, -100 * ONE, 2 * ONE,
                                 200 * ONE, 0, 0));
      send_move_request(make_req(CMD_WRITE, 1, -5 * ONE, 20 * ONE, 10 * ONE,
                                 2 * ONE, 0, 0));
      write_blocker_count(2);
      // free move
      send_move_request(make_req(CMD_RESOLVE, 0, 0, 0, ONE, ONE, 5 * ONE, 0));
      // x runs into the wall
      send_move_request(make_req(CMD_RESOLVE, 0, 8 * ONE, 0, ONE, ONE, 2 * ONE, 0));
      // right edge just touches the wall: strict compare lets it pass
      send_move_request(make_req(CMD_RESOLVE, 0, 8 * ONE, 0, ONE, ONE, ONE, 0));
      // y runs into the floor
      send_move_request(make_req(CMD_RESOLVE, 0, 0, 17 * ONE, ONE, ONE, 0, 3 * ONE));
      // both axes stopped
      send_move_request(make_req(CMD_RESOLVE, 0, 4 * ONE, 17 * ONE, ONE, ONE,
                                 7 * ONE, 3 * ONE));
      // allowed x move carries the mover over the floor
      send_move_request(make_req(CMD_RESOLVE, 0, -8 * ONE, 17 * ONE, ONE, ONE,
                                 4 * ONE, 3 * ONE));
      // x stopped; the y test must use zero x or it would hit the wall
      send_move_request(make_req(CMD_RESOLVE, 0, 6 * ONE, 17 * ONE, ONE, ONE,
                                 5 * ONE, 3 * ONE));
   endtask

   // Entry 2 sits at the top of the x range and its right edge wraps negative;
   // entry 3 sits at the bottom, reachable only by a mover whose x wraps.
   task automatic test_edge_wrap();
      send_move_request(make_req(CMD_WRITE, 2, 8388352, 0, 512, 4 * ONE, 0, 0));
      send_move_request(make_req(CMD_WRITE, 3, COORD_MIN, 0, 4096, 4 * ONE, 0, 0));
      write_blocker_count(4);
      send_move_request(make_req(CMD_RESOLVE, 0, 8388096, 0, ONE, ONE, 0, 0));
      send_move_request(make_req(CMD_RESOLVE, 0, 8388352, 0, ONE, ONE, 512, 0));
   endtask

   // Field extremes; a write carries move values and a resolve carries an index,
   // both of which the block must ignore.
   task automatic test_field_extremes();
      send_move_request(make_req(CMD_WRITE, 63, COORD_MAX, COORD_MIN, COORD_MAX,
                                 COORD_MAX, COORD_MIN, COORD_MAX));
      send_move_request(make_req(CMD_RESOLVE, 63, COORD_MAX, COORD_MIN, COORD_MAX, 0,
                                 COORD_MIN, COORD_MAX));
      send_move_request(make_req(CMD_RESOLVE, 42, COORD_MIN, COORD_MAX, 0, COORD_MAX,
                                 COORD_MAX, COORD_MIN));
      // zero-size mover inside the wall still counts as overlapping
      send_move_request(make_req(CMD_RESOLVE, 0, 11 * ONE, 0, 0, 0, 0, 0));
   endtask

   // Fill every entry, then run the full table and a count past the table depth.
   task automatic test_full_table();
      move_req_t r;
      for (int i = 0; i < AmrMaxBlockers; i++) begin
         r         = random_request();
         r.command = CMD_WRITE;
         r.index   = slot_t'(i);
         send_move_request(r);
      end
      write_blocker_count(AmrMaxBlockers);
      repeat (40) send_move_request(random_request());
      write_blocker_count(2 ** CNT_W - 1);
      repeat (40) send_move_request(random_request());
   endtask

   // Receiver holds off long enough that the output register and the result stage
   // both fill and the request side stalls behind them.
   task automatic test_output_backpressure();
      move_req_t r;
      send_idle_pct = 0;
      recv_idle_pct = 0;
      write_blocker_count(AmrMaxBlockers);
      rsp_hold_cycles = HOLD_CYCLES;
      repeat (12) begin
         r         = random_request();
         r.command = CMD_RESOLVE;
         send_move_request(r);
      end
   endtask

   // Mixed traffic in four slices, each under a new count: the extremes first,
   // then a random one within the table and one up to the largest register value.
   task automatic test_random_traffic(input int snd_pct, input int rcv_pct,
                                      input int items);
      int count;
      send_idle_pct = snd_pct;
      recv_idle_pct = rcv_pct;
      for (int s = 0; s < 4; s++) begin
         case (s)
            0: count = 0;
            1: count = AmrMaxBlockers;
            2: count = $urandom_range(AmrMaxBlockers);
            default: count = $urandom_range(2 ** CNT_W - 1);
         endcase
         write_blocker_count(count);
         repeat (items / 4) send_move_request(random_request());
      end
   endtask

   // ---------------------------------------------------------------------------
   // Response side: random ready, plus a counted hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      rsp_ch.ready = 1'b0;
      forever begin
         @(negedge clock);
         if (rsp_hold_cycles > 0) begin
            rsp_ch.ready = 1'b0;
            rsp_hold_cycles--;
         end else begin
            rsp_ch.ready = ($urandom_range(99) >= recv_idle_pct);
         end
      end
   end

   // Each response transfer is matched against the oldest owed move.
   always @(posedge clock) begin
      if (!reset && rsp_ch.valid === 1'b1 && rsp_ch.ready) begin
         if (pending_moves.size() == 0) begin
            $error("response transfer with no resolve outstanding");
            fail_count++;
         end else begin
            checked_move = pending_moves.pop_front();
            resolves_checked++;
            if (rsp_ch.resolved_x !== checked_move.res_x) begin
               $error("resolved_x: expected %0d, got %0d", checked_move.res_x,
                      rsp_ch.resolved_x);
               fail_count++;
            end
            if (rsp_ch.resolved_y !== checked_move.res_y) begin
               $error("resolved_y: expected %0d, got %0d", checked_move.res_y,
                      rsp_ch.resolved_y);
               fail_count++;
            end
            if (rsp_ch.x_blocked !== checked_move.x_blk) begin
               $error("x_blocked: expected %0d, got %0d", checked_move.x_blk,
                      rsp_ch.x_blocked);
               fail_count++;
            end
            if (rsp_ch.y_blocked !== checked_move.y_blk) begin
               $error("y_blocked: expected %0d, got %0d", checked_move.y_blk,
                      rsp_ch.y_blocked);
               fail_count++;
            end
         end
      end
   end

   // Watchdog: any transfer on either channel restarts the count.
   always @(posedge clock) begin
      if ((req_ch.valid === 1'b1 && req_ch.ready === 1'b1) ||
          (rsp_ch.valid === 1'b1 && rsp_ch.ready === 1'b1))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("watchdog: no transfer for %0d cycles", quiet_cycles);
         $display("RESULT: ERROR");
         $finish;
      end
   end

   // ---------------------------------------------------------------------------
   // Test sequence
   // ---------------------------------------------------------------------------
   initial begin
      reset           = 1'b1;
      csr_wr_en       = 1'b0;
      csr_wr_data     = '0;
      active_blockers = '0;
      req_ch.valid    = 1'b0;
      req_ch.command  = CMD_WRITE;
      req_ch.index    = '0;
      req_ch.rect_x   = '0;
      req_ch.rect_y   = '0;
      req_ch.rect_w   = '0;
      req_ch.rect_h   = '0;
      req_ch.move_x   = '0;
      req_ch.move_y   = '0;
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_zero_count();
      test_axis_blocking();
      test_edge_wrap();
      test_field_extremes();
      test_full_table();
      test_output_backpressure();
      test_random_traffic(15, 48, 300);
      test_random_traffic(48, 15, 300);
      test_random_traffic(0, 0, 300);

      wait_block_idle();
      $display("covered %0d blocker writes and %0d resolves (%0d checked)",
               writes_sent, resolves_sent, resolves_checked);
      $display("  x stopped %0d times, y stopped %0d times, counts 0 to %0d",
               x_stops, y_stops, 2 ** CNT_W - 1);
      if (fail_count == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule
